// ===== src/dfrq_pkg.sv =====
// Shared types and constants for the delayed fault report queue.
package dfrq_pkg;

  localparam int unsigned CODE_W    = 8;
  localparam int unsigned TIMER_W   = 8;
  localparam int unsigned PENDING_W = 5;

  localparam logic [TIMER_W-1:0] HOLD_RESET = 8'd20;

  // Command codes carried by the input beat.
  localparam logic CMD_REPORT = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  // One slot of the table as stored in memory.
  typedef struct packed {
    logic [CODE_W-1:0]  code;
    logic [TIMER_W-1:0] timer;
  } slot_t;

  // One result beat.
  typedef struct packed {
    logic                 sent;
    logic [CODE_W-1:0]    sent_code;
    logic [PENDING_W-1:0] pending_count;
  } result_t;

endpackage

// ===== src/dfrq_slot_mem.sv =====
// Single-port-write, single-port-read slot memory with registered read data.
module dfrq_slot_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic              clk_i,
  input  logic              rd_en_i,
  input  logic [AW-1:0]     rd_addr_i,
  output dfrq_pkg::slot_t   rd_data_o,
  input  logic              we_i,
  input  logic [AW-1:0]     wr_addr_i,
  input  dfrq_pkg::slot_t   wr_data_i
);
  import dfrq_pkg::*;

  slot_t mem_q [DEPTH];
  slot_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== src/dfrq_engine.sv =====
// Sweep controller: one slot memory pass per command, bar a zero code or empty-table tick, then commits the result.
module dfrq_engine #(
  parameter int unsigned SLOTS = 16,
  parameter int unsigned AW    = 4,
  parameter int unsigned CW    = 5
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              command_i,
  input  logic [dfrq_pkg::CODE_W-1:0]       fault_code_i,
  input  logic [dfrq_pkg::TIMER_W-1:0]      hold_i,
  output logic                              mem_rd_en_o,
  output logic [AW-1:0]                     mem_rd_addr_o,
  input  dfrq_pkg::slot_t                   mem_rd_data_i,
  output logic                              mem_we_o,
  output logic [AW-1:0]                     mem_wr_addr_o,
  output dfrq_pkg::slot_t                   mem_wr_data_o,
  output logic                              res_valid_o,
  output dfrq_pkg::result_t                 res_o,
  input  logic                              res_take_i
);
  import dfrq_pkg::*;

  localparam int unsigned NW = $clog2(SLOTS + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SWEEP = 2'd1;
  localparam logic [1:0] ST_FIN   = 2'd2;

  logic [1:0]         state_q, state_d;
  logic               cmd_q, cmd_d;
  logic [CODE_W-1:0]  code_q, code_d;
  logic [NW-1:0]      n_q, n_d;
  logic               rd_vld_q, rd_vld_d;
  logic [AW-1:0]      rd_idx_q, rd_idx_d;
  logic               hit_q, hit_d;
  logic [AW-1:0]      hit_idx_q, hit_idx_d;
  logic [CODE_W-1:0]  hit_code_q, hit_code_d;
  logic               free_q, free_d;
  logic [AW-1:0]      free_idx_q, free_idx_d;
  logic [SLOTS-1:0]   vld_q, vld_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [AW-1:0]      ptr_q, ptr_d;

  logic [AW:0]        addr_sum;
  logic [AW:0]        addr_wrap;
  slot_t              word;
  logic [TIMER_W-1:0] new_timer;
  logic               ins;
  logic               emit;
  logic [CW-1:0]      cnt_next;
  logic [CW+4:0]      cnt_ext;

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    code_d     = code_q;
    n_d        = n_q;
    rd_vld_d   = rd_vld_q;
    rd_idx_d   = rd_idx_q;
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    hit_code_d = hit_code_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    vld_d      = vld_q;
    cnt_d      = cnt_q;
    ptr_d      = ptr_q;

    mem_rd_en_o   = 1'b0;
    mem_we_o      = 1'b0;
    mem_wr_addr_o = rd_idx_q;
    mem_wr_data_o = '0;
    res_valid_o   = 1'b0;
    in_stall_o    = (state_q != ST_IDLE);

    // Round-robin address for ticks, plain ascending order for reports.
    addr_sum  = {1'b0, ptr_q} + {1'b0, n_q[AW-1:0]};
    addr_wrap = (addr_sum >= (AW+1)'(SLOTS)) ? addr_sum - (AW+1)'(SLOTS) : addr_sum;
    mem_rd_addr_o = (cmd_q == CMD_TICK) ? addr_wrap[AW-1:0] : n_q[AW-1:0];

    // A slot that is not occupied reads as the reset value.
    word      = vld_q[rd_idx_q] ? mem_rd_data_i : '0;
    new_timer = (word.timer != '0) ? word.timer - TIMER_W'(1) : word.timer;

    ins      = (cmd_q == CMD_REPORT) && !hit_q && free_q;
    emit     = (cmd_q == CMD_TICK) && hit_q;
    cnt_next = cnt_q + CW'(ins) - CW'(emit);
    cnt_ext  = (CW+5)'(cnt_next);

    res_o.sent          = emit;
    res_o.sent_code     = emit ? hit_code_q : '0;
    res_o.pending_count = cnt_ext[PENDING_W-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_d    = command_i;
          code_d   = fault_code_i;
          n_d      = '0;
          rd_vld_d = 1'b0;
          hit_d    = 1'b0;
          free_d   = 1'b0;
          // A zero code or a tick on an empty table changes nothing.
          if ((command_i == CMD_REPORT && fault_code_i == '0) ||
              (command_i == CMD_TICK && cnt_q == '0)) begin
            state_d = ST_FIN;
          end else begin
            state_d = ST_SWEEP;
          end
        end
      end
      ST_SWEEP: begin
        if (n_q < NW'(SLOTS)) begin
          mem_rd_en_o = 1'b1;
          n_d         = n_q + NW'(1);
          rd_vld_d    = 1'b1;
          rd_idx_d    = mem_rd_addr_o;
        end else begin
          rd_vld_d = 1'b0;
        end
        if (rd_vld_q) begin
          if (cmd_q == CMD_REPORT) begin
            if (vld_q[rd_idx_q] && word.code == code_q) begin
              hit_d = 1'b1;
            end
            if (!vld_q[rd_idx_q]) begin
              free_d     = 1'b1;
              free_idx_d = rd_idx_q;
            end
          end else if (vld_q[rd_idx_q]) begin
            mem_we_o      = 1'b1;
            mem_wr_addr_o = rd_idx_q;
            mem_wr_data_o = '{code: word.code, timer: new_timer};
            if (!hit_q && new_timer == '0) begin
              hit_d      = 1'b1;
              hit_idx_d  = rd_idx_q;
              hit_code_d = word.code;
            end
          end
          if (n_q == NW'(SLOTS)) begin
            state_d = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        res_valid_o = 1'b1;
        if (res_take_i) begin
          if (ins) begin
            mem_we_o          = 1'b1;
            mem_wr_addr_o     = free_idx_q;
            mem_wr_data_o     = '{code: code_q, timer: hold_i};
            vld_d[free_idx_q] = 1'b1;
          end
          if (emit) begin
            vld_d[hit_idx_q] = 1'b0;
            ptr_d = (hit_idx_q == AW'(SLOTS - 1)) ? '0 : hit_idx_q + AW'(1);
          end
          cnt_d   = cnt_next;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rd_vld_q <= 1'b0;
      vld_q    <= '0;
      cnt_q    <= '0;
      ptr_q    <= '0;
      n_q      <= '0;
      hit_q    <= 1'b0;
      free_q   <= 1'b0;
      cmd_q    <= CMD_REPORT;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= rd_vld_d;
      vld_q    <= vld_d;
      cnt_q    <= cnt_d;
      ptr_q    <= ptr_d;
      n_q      <= n_d;
      hit_q    <= hit_d;
      free_q   <= free_d;
      cmd_q    <= cmd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q     <= code_d;
    rd_idx_q   <= rd_idx_d;
    hit_idx_q  <= hit_idx_d;
    hit_code_q <= hit_code_d;
    free_idx_q <= free_idx_d;
  end

  // The occupancy count always agrees with the valid bits.
  a_cnt_matches_vld: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(vld_q) == int'(cnt_q))
    else $error("occupancy count disagrees with valid bits");

  a_cnt_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(SLOTS))
    else $error("occupancy count exceeds table size");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o |-> state_q != ST_IDLE)
    else $error("memory written while idle");

  a_rd_addr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_rd_en_o |-> mem_rd_addr_o <= AW'(SLOTS - 1))
    else $error("sweep address beyond table");

  a_sent_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_take_i && res_o.sent) |-> res_o.sent_code != '0)
    else $error("emitted an empty fault code");

endmodule

// ===== src/dfrq_out_stage.sv =====
// Output register that holds a result beat until the receiver takes it.
module dfrq_out_stage (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          res_valid_i,
  input  dfrq_pkg::result_t             res_i,
  output logic                          res_take_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output dfrq_pkg::result_t             out_o
);
  import dfrq_pkg::*;

  logic    valid_q, valid_d;
  result_t data_q;
  logic    load;

  // The register may be refilled in the same cycle that its beat leaves.
  assign res_take_o = !valid_q || !out_stall_i;
  assign load       = res_valid_i && res_take_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = data_q;

endmodule

// ===== src/delayed_fault_report_queue.sv =====
// Top level of the delayed fault report queue.
//
//   channel   direction  handshake                 payload
//   --------  ---------  ------------------------  --------------------------------------
//   input     in         in_valid_i / in_stall_o   command_i, fault_code_i
//   output    out        out_valid_o / out_stall_i sent_o, sent_code_o, pending_count_o
//   config    in         hold_ticks_we_i           hold_ticks_i
//
// A report of a nonzero code or a tick on a nonempty table sweeps the table:
// one read per slot is issued on the single memory read port, the last read word
// is handled, and the result is committed to the output register. A zero code or
// a tick on an empty table goes straight to the commit. One command is in flight
// at a time; in_stall_o is high while it is. If the output register still holds
// an untaken beat, the commit waits.
// Reset clears all slots at once through per-slot valid bits; no clearing pass.
module delayed_fault_report_queue #(
  parameter int unsigned SLOTS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              command_i,
  input  logic [dfrq_pkg::CODE_W-1:0]       fault_code_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              sent_o,
  output logic [dfrq_pkg::CODE_W-1:0]       sent_code_o,
  output logic [dfrq_pkg::PENDING_W-1:0]    pending_count_o,
  input  logic                              hold_ticks_we_i,
  input  logic [dfrq_pkg::TIMER_W-1:0]      hold_ticks_i
);
  import dfrq_pkg::*;

  localparam int unsigned AW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);

  // The hold time loaded into each newly stored fault.
  logic [TIMER_W-1:0] hold_q;

  logic          mem_rd_en;
  logic [AW-1:0] mem_rd_addr;
  slot_t         mem_rd_data;
  logic          mem_we;
  logic [AW-1:0] mem_wr_addr;
  slot_t         mem_wr_data;

  logic          res_valid;
  result_t       res;
  logic          res_take;
  result_t       out_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= HOLD_RESET;
    end else if (hold_ticks_we_i) begin
      hold_q <= hold_ticks_i;
    end
  end

  // Slot codes and timers live together in one memory word per slot.
  dfrq_slot_mem #(
    .DEPTH (SLOTS),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data),
    .we_i      (mem_we),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data)
  );

  // The engine sweeps every slot once per command, bar a zero code or an empty-table
  // tick. In a sweep each slot is read once, and a tick writes each occupied slot back
  // once, so read and write never meet on the same entry and no forwarding is needed.
  dfrq_engine #(
    .SLOTS (SLOTS),
    .AW    (AW),
    .CW    (CW)
  ) u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .fault_code_i  (fault_code_i),
    .hold_i        (hold_q),
    .mem_rd_en_o   (mem_rd_en),
    .mem_rd_addr_o (mem_rd_addr),
    .mem_rd_data_i (mem_rd_data),
    .mem_we_o      (mem_we),
    .mem_wr_addr_o (mem_wr_addr),
    .mem_wr_data_o (mem_wr_data),
    .res_valid_o   (res_valid),
    .res_o         (res),
    .res_take_i    (res_take)
  );

  // The output register lets the engine finish while the receiver stalls.
  dfrq_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .res_take_o  (res_take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_res)
  );

  assign sent_o          = out_res.sent;
  assign sent_code_o     = out_res.sent_code;
  assign pending_count_o = out_res.pending_count;

endmodule

// ===== sim/delayed_fault_report_queue_tb.sv =====
// Self-checking testbench for the delayed fault report queue.
`timescale 1ns / 1ps

module delayed_fault_report_queue_tb;
  import dfrq_pkg::*;

  localparam int unsigned SLOTS          = 16;
  localparam int unsigned DRAIN_CYCLES   = SLOTS + 6;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  // One command beat as queued for the driver.
  typedef struct {
    logic              cmd;
    logic [CODE_W-1:0] code;
  } fault_cmd_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic                 command_i;
  logic [CODE_W-1:0]    fault_code_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic                 sent_o;
  logic [CODE_W-1:0]    sent_code_o;
  logic [PENDING_W-1:0] pending_count_o;
  logic                 hold_ticks_we_i;
  logic [TIMER_W-1:0]   hold_ticks_i;

  // Commands waiting to be driven, and results the table model says must come back.
  fault_cmd_t pending_cmds[$];
  result_t    expected_results[$];

  // Shadow copy of the slot table, kept in step with every accepted command beat.
  logic [CODE_W-1:0]  shadow_code[SLOTS];
  logic [TIMER_W-1:0] shadow_timer[SLOTS];
  int unsigned        shadow_occupied;
  int unsigned        shadow_scan_ptr;
  logic [TIMER_W-1:0] shadow_hold;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned mismatch_count;
  int unsigned quiet_cycles;

  delayed_fault_report_queue #(
    .SLOTS(SLOTS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .fault_code_i   (fault_code_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .sent_o         (sent_o),
    .sent_code_o    (sent_code_o),
    .pending_count_o(pending_count_o),
    .hold_ticks_we_i(hold_ticks_we_i),
    .hold_ticks_i   (hold_ticks_i)
  );

  always #10 clk_i = ~clk_i;

  // Applies one command to the shadow table and returns the result beat it must produce.
  // A report stores a new nonzero code in the highest free slot; a tick on a nonempty
  // table ages every running timer, then emits the first expired code found
  // round-robin from the scan pointer.
  function automatic result_t apply_fault_step(input logic cmd, input logic [CODE_W-1:0] code);
    result_t     res;
    bit          done;
    int          i;
    int unsigned idx;
    res  = '0;
    done = 1'b0;
    if (cmd == CMD_REPORT) begin
      if (code != '0) begin
        // A code already in the table keeps its slot and its running timer.
        for (i = 0; i < SLOTS; i++) begin
          if (shadow_code[i] == code) begin
            done = 1'b1;
          end
        end
        // With no free slot left the report is simply lost.
        for (i = SLOTS - 1; i >= 0; i--) begin
          if (!done && shadow_code[i] == '0) begin
            shadow_code[i]  = code;
            shadow_timer[i] = shadow_hold;
            shadow_occupied++;
            done = 1'b1;
          end
        end
      end
    end else if (shadow_occupied != 0) begin
      for (i = 0; i < SLOTS; i++) begin
        if (shadow_timer[i] != '0) begin
          shadow_timer[i] = shadow_timer[i] - 1'b1;
        end
      end
      // The pointer only moves when something is emitted.
      for (i = 0; i < SLOTS; i++) begin
        idx = (shadow_scan_ptr + i) % SLOTS;
        if (!done && shadow_code[idx] != '0 && shadow_timer[idx] == '0) begin
          res.sent        = 1'b1;
          res.sent_code   = shadow_code[idx];
          shadow_code[idx]  = '0;
          shadow_timer[idx] = '0;
          shadow_occupied--;
          shadow_scan_ptr = (idx + 1) % SLOTS;
          done = 1'b1;
        end
      end
    end
    res.pending_count = shadow_occupied[PENDING_W-1:0];
    return res;
  endfunction

  // Random command mix: codes favor a small pool so that duplicates and a full table
  // are common, with zero codes and the full code range mixed in.
  function automatic fault_cmd_t random_fault_cmd(input int unsigned report_pct);
    fault_cmd_t  c;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      c.code = '0;
    end else if (pick < 60) begin
      c.code = CODE_W'($urandom_range(1, 24));
    end else begin
      c.code = CODE_W'($urandom_range(0, 255));
    end
    c.cmd = ($urandom_range(0, 99) < report_pct) ? CMD_REPORT : CMD_TICK;
    return c;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (mismatch_count < 100) begin
      $display("ERROR %0t: %s: got %0d, expected %0d", $realtime, what, got, want);
    end
    mismatch_count++;
  endtask

  // The register is only written while the block is idle, so the shadow copy can follow
  // it right away.
  task automatic write_hold_ticks(input logic [TIMER_W-1:0] value);
    @(posedge clk_i);
    hold_ticks_we_i <= 1'b1;
    hold_ticks_i    <= value;
    shadow_hold = value;
    @(posedge clk_i);
    hold_ticks_we_i <= 1'b0;
    hold_ticks_i    <= TIMER_W'($urandom_range(0, 255));
  endtask

  // Waits until every queued command was taken and every result beat has come back,
  // then lets the block settle before anything else changes.
  task automatic wait_drained();
    @(negedge clk_i);
    while (pending_cmds.size() != 0 || expected_results.size() != 0 || in_valid_i) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [TIMER_W-1:0] hold, input int unsigned send_pct,
                           input int unsigned recv_pct, input int unsigned count,
                           input int unsigned report_pct);
    int unsigned n;
    write_hold_ticks(hold);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (n = 0; n < count; n++) begin
      pending_cmds.push_back(random_fault_cmd(report_pct));
    end
    wait_drained();
  endtask

  // Command driver: a new beat is only offered once the current one was accepted, so
  // a stalled beat holds its payload.
  always @(posedge clk_i) begin : cmd_driver
    fault_cmd_t next_cmd;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_results.push_back(apply_fault_step(command_i, fault_code_i));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_cmd = pending_cmds.pop_front();
          in_valid_i   <= 1'b1;
          command_i    <= next_cmd.cmd;
          fault_code_i <= next_cmd.code;
        end else begin
          in_valid_i   <= 1'b0;
          command_i    <= 1'($urandom_range(0, 1));
          fault_code_i <= CODE_W'($urandom_range(0, 255));
        end
      end
    end
  end

  // Result monitor: each accepted result beat is checked against the oldest expectation.
  always @(posedge clk_i) begin : result_monitor
    result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result beat with nothing expected", sent_code_o, 0);
        end else begin
          want = expected_results.pop_front();
          if (sent_o !== want.sent) begin
            report_mismatch("sent", sent_o, want.sent);
          end
          if (sent_code_o !== want.sent_code) begin
            report_mismatch("sent_code", sent_code_o, want.sent_code);
          end
          if (pending_count_o !== want.pending_count) begin
            report_mismatch("pending_count", pending_count_o, want.pending_count);
          end
        end
      end
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Watchdog: a run of cycles with no beat on either channel means the block hung.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("delayed_fault_report_queue: mismatch");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned k;
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    command_i       = CMD_REPORT;
    fault_code_i    = '0;
    out_stall_i     = 1'b0;
    hold_ticks_we_i = 1'b0;
    hold_ticks_i    = '0;
    send_idle_pct   = 19;
    recv_idle_pct   = 56;
    mismatch_count  = 0;
    quiet_cycles    = 0;
    for (k = 0; k < SLOTS; k++) begin
      shadow_code[k]  = '0;
      shadow_timer[k] = '0;
    end
    shadow_occupied = 0;
    shadow_scan_ptr = 0;
    shadow_hold     = HOLD_RESET;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part under the reset hold time: a zero code, a tick on an empty table,
    // a report and its duplicate, and a tick that finds nothing expired yet.
    pending_cmds.push_back('{cmd: CMD_REPORT, code: 8'h00});
    pending_cmds.push_back('{cmd: CMD_TICK,   code: 8'hFF});
    pending_cmds.push_back('{cmd: CMD_REPORT, code: 8'hFF});
    pending_cmds.push_back('{cmd: CMD_REPORT, code: 8'hFF});
    pending_cmds.push_back('{cmd: CMD_TICK,   code: 8'h00});
    wait_drained();

    // With a zero hold time a fresh code goes out on the very next tick. Then the table
    // is filled to the last slot, one more report is dropped, and a tick emits one.
    write_hold_ticks(8'd0);
    pending_cmds.push_back('{cmd: CMD_REPORT, code: 8'h01});
    pending_cmds.push_back('{cmd: CMD_TICK,   code: 8'h55});
    for (k = 2; k <= SLOTS + 1; k++) begin
      pending_cmds.push_back('{cmd: CMD_REPORT, code: CODE_W'(k)});
    end
    pending_cmds.push_back('{cmd: CMD_REPORT, code: 8'h80});
    pending_cmds.push_back('{cmd: CMD_TICK,   code: 8'hAA});
    wait_drained();

    // Random part: sender idles lightly and the receiver heavily, then the reverse,
    // then both run flat out. The phase boundaries also make the sender wait until
    // every result is in.
    run_phase(8'd0,   19, 56, 300, 40);
    run_phase(8'd7,   19, 56, 300, 40);
    run_phase(8'd255, 56, 19, 400, 35);
    run_phase(8'd3,   56, 19, 250, 45);
    run_phase(TIMER_W'($urandom_range(0, 40)), 0, 0, 250, 40);
    run_phase(8'd1,   0,  0,  250, 50);

    if (mismatch_count == 0) begin
      $display("delayed_fault_report_queue: match");
    end else begin
      $display("delayed_fault_report_queue: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/dfrq_pkg.sv
src/dfrq_slot_mem.sv
src/dfrq_engine.sv
src/dfrq_out_stage.sv
src/delayed_fault_report_queue.sv
sim/delayed_fault_report_queue_tb.sv
